// ----- rtl/core/jsu_pkg.sv -----
// Shared types, character codes and helper functions of the JSON string unescaper.
package jsu_pkg;

    localparam int MAX_OUT   = 9;
    localparam int OUT_CNT_W = 4;

    typedef logic [7:0] byte_t;
    typedef byte_t [MAX_OUT-1:0] obuf_t;

    // Scanner position within a pending escape.
    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_BSL,
        MODE_HEX,
        MODE_HIGH,
        MODE_HIGH_BSL,
        MODE_HIGH_HEX
    } mode_t;

    typedef struct packed {
        mode_t           mode;
        logic [1:0]      ndig;
        logic [11:0]     acc;
        byte_t [2:0]     dig;
        logic [15:0]     hi;
    } scan_t;

    typedef struct packed {
        obuf_t                bytes;
        logic [OUT_CNT_W-1:0] count;
        logic                 fin;
    } dec_out_t;

    localparam byte_t CH_BSL   = 8'h5C;
    localparam byte_t CH_U     = 8'h75;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;
    localparam byte_t CH_LA    = 8'h61;
    localparam byte_t CH_LF    = 8'h66;
    localparam byte_t CH_UA    = 8'h41;
    localparam byte_t CH_UF    = 8'h46;
    localparam byte_t CH_B     = 8'h62;
    localparam byte_t CH_F     = 8'h66;
    localparam byte_t CH_N     = 8'h6E;
    localparam byte_t CH_R     = 8'h72;
    localparam byte_t CH_T     = 8'h74;

    localparam byte_t CTL_BS   = 8'h08;
    localparam byte_t CTL_FF   = 8'h0C;
    localparam byte_t CTL_LF   = 8'h0A;
    localparam byte_t CTL_CR   = 8'h0D;
    localparam byte_t CTL_TAB  = 8'h09;

    localparam byte_t UTF8_LEAD2 = 8'hC0;
    localparam byte_t UTF8_LEAD3 = 8'hE0;
    localparam byte_t UTF8_LEAD4 = 8'hF0;
    localparam byte_t UTF8_CONT  = 8'h80;

    localparam logic [15:0] CP_ONE_MAX = 16'h007F;
    localparam logic [15:0] CP_TWO_MAX = 16'h07FF;
    localparam logic [15:0] HIGH_MIN   = 16'hD800;
    localparam logic [15:0] HIGH_MAX   = 16'hDBFF;
    localparam logic [15:0] LOW_MIN    = 16'hDC00;
    localparam logic [15:0] LOW_MAX    = 16'hDFFF;

    localparam logic [4:0] HEX_BAD = 5'h10;

    // Bit 4 set marks a byte that is not a hex digit.
    function automatic logic [4:0] hex_digit(input byte_t c);
        logic [4:0] r;
        r = HEX_BAD;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            r = {1'b0, c[3:0]};
        end
        else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
        begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic byte_t simple_escape(input byte_t e);
        byte_t r;
        unique case (e)
            CH_B:    r = CTL_BS;
            CH_F:    r = CTL_FF;
            CH_N:    r = CTL_LF;
            CH_R:    r = CTL_CR;
            CH_T:    r = CTL_TAB;
            default: r = e;
        endcase
        return r;
    endfunction

    function automatic logic is_high(input logic [15:0] v);
        return (v >= HIGH_MIN) && (v <= HIGH_MAX);
    endfunction

    function automatic logic is_low(input logic [15:0] v);
        return (v >= LOW_MIN) && (v <= LOW_MAX);
    endfunction

endpackage

// ----- rtl/core/jsu_decode.sv -----
// Single-pass decode of one raw byte against the pending escape state.
module jsu_decode (
    input  jsu_pkg::scan_t    st,
    input  jsu_pkg::byte_t    c,
    input  logic              fin,
    output jsu_pkg::scan_t    nst,
    output jsu_pkg::dec_out_t res
);

    typedef struct packed {
        jsu_pkg::obuf_t                 b;
        logic [jsu_pkg::OUT_CNT_W-1:0]  n;
    } ebuf_t;

    function automatic ebuf_t put(input ebuf_t e, input jsu_pkg::byte_t x);
        ebuf_t r;
        r = e;
        r.b[r.n] = x;
        r.n = r.n + 4'd1;
        return r;
    endfunction

    function automatic ebuf_t put_cp(input ebuf_t e, input logic [15:0] v);
        ebuf_t r;
        r = e;
        if (v <= jsu_pkg::CP_ONE_MAX)
        begin
            r = put(r, v[7:0]);
        end
        else if (v <= jsu_pkg::CP_TWO_MAX)
        begin
            r = put(r, jsu_pkg::UTF8_LEAD2 | {3'b000, v[10:6]});
            r = put(r, jsu_pkg::UTF8_CONT | {2'b00, v[5:0]});
        end
        else
        begin
            r = put(r, jsu_pkg::UTF8_LEAD3 | {4'b0000, v[15:12]});
            r = put(r, jsu_pkg::UTF8_CONT | {2'b00, v[11:6]});
            r = put(r, jsu_pkg::UTF8_CONT | {2'b00, v[5:0]});
        end
        return r;
    endfunction

    // Join a surrogate pair into a four-byte sequence.
    function automatic ebuf_t put_pair(input ebuf_t e, input logic [15:0] hi,
                                       input logic [15:0] lo);
        ebuf_t      r;
        logic [4:0] plane;
        r = e;
        plane = {1'b0, hi[9:6]} + 5'd1;
        r = put(r, jsu_pkg::UTF8_LEAD4 | {5'b00000, plane[4:2]});
        r = put(r, jsu_pkg::UTF8_CONT | {2'b00, plane[1:0], hi[5:2]});
        r = put(r, jsu_pkg::UTF8_CONT | {2'b00, hi[1:0], lo[9:6]});
        r = put(r, jsu_pkg::UTF8_CONT | {2'b00, lo[5:0]});
        return r;
    endfunction

    // Replay a broken \u and its digits as literal text.
    function automatic ebuf_t put_literal(input ebuf_t e, input logic [1:0] ndig,
                                          input jsu_pkg::byte_t [2:0] dig);
        ebuf_t r;
        r = e;
        r = put(r, jsu_pkg::CH_BSL);
        r = put(r, jsu_pkg::CH_U);
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < ndig)
            begin
                r = put(r, dig[i]);
            end
        end
        return r;
    endfunction

    ebuf_t       e;
    logic [4:0]  h;
    logic        h_ok;
    logic [15:0] word;

    always_comb
    begin
        e         = '0;
        nst       = st;
        nst.mode  = jsu_pkg::MODE_PLAIN;
        nst.ndig  = 2'd0;
        h         = jsu_pkg::hex_digit(c);
        h_ok      = ~h[4];
        word      = {st.acc, h[3:0]};

        unique case (st.mode)
            jsu_pkg::MODE_PLAIN:
            begin
                if (c == jsu_pkg::CH_BSL && !fin)
                    nst.mode = jsu_pkg::MODE_BSL;
                else
                    e = put(e, c);
            end
            jsu_pkg::MODE_BSL:
            begin
                if (c != jsu_pkg::CH_U)
                begin
                    e = put(e, jsu_pkg::simple_escape(c));
                end
                else if (fin)
                begin
                    e = put(e, jsu_pkg::CH_BSL);
                    e = put(e, jsu_pkg::CH_U);
                end
                else
                begin
                    nst.mode = jsu_pkg::MODE_HEX;
                end
            end
            jsu_pkg::MODE_HEX:
            begin
                if (!h_ok)
                begin
                    e = put_literal(e, st.ndig, st.dig);
                    if (c == jsu_pkg::CH_BSL && !fin)
                        nst.mode = jsu_pkg::MODE_BSL;
                    else
                        e = put(e, c);
                end
                else if (st.ndig != 2'd3)
                begin
                    if (fin)
                    begin
                        e = put_literal(e, st.ndig, st.dig);
                        e = put(e, c);
                    end
                    else
                    begin
                        nst.mode         = jsu_pkg::MODE_HEX;
                        nst.dig[st.ndig] = c;
                        nst.acc          = {st.acc[7:0], h[3:0]};
                        nst.ndig         = st.ndig + 2'd1;
                    end
                end
                else if (jsu_pkg::is_high(word) && !fin)
                begin
                    nst.mode = jsu_pkg::MODE_HIGH;
                    nst.hi   = word;
                end
                else
                begin
                    e = put_cp(e, word);
                end
            end
            jsu_pkg::MODE_HIGH:
            begin
                if (c == jsu_pkg::CH_BSL && !fin)
                begin
                    nst.mode = jsu_pkg::MODE_HIGH_BSL;
                end
                else
                begin
                    e = put_cp(e, st.hi);
                    e = put(e, c);
                end
            end
            jsu_pkg::MODE_HIGH_BSL:
            begin
                if (c != jsu_pkg::CH_U)
                begin
                    e = put_cp(e, st.hi);
                    e = put(e, jsu_pkg::simple_escape(c));
                end
                else if (fin)
                begin
                    e = put_cp(e, st.hi);
                    e = put(e, jsu_pkg::CH_BSL);
                    e = put(e, jsu_pkg::CH_U);
                end
                else
                begin
                    nst.mode = jsu_pkg::MODE_HIGH_HEX;
                end
            end
            jsu_pkg::MODE_HIGH_HEX:
            begin
                if (!h_ok)
                begin
                    e = put_cp(e, st.hi);
                    e = put_literal(e, st.ndig, st.dig);
                    if (c == jsu_pkg::CH_BSL && !fin)
                        nst.mode = jsu_pkg::MODE_BSL;
                    else
                        e = put(e, c);
                end
                else if (st.ndig != 2'd3)
                begin
                    if (fin)
                    begin
                        e = put_cp(e, st.hi);
                        e = put_literal(e, st.ndig, st.dig);
                        e = put(e, c);
                    end
                    else
                    begin
                        nst.mode         = jsu_pkg::MODE_HIGH_HEX;
                        nst.dig[st.ndig] = c;
                        nst.acc          = {st.acc[7:0], h[3:0]};
                        nst.ndig         = st.ndig + 2'd1;
                    end
                end
                else if (jsu_pkg::is_low(word))
                begin
                    e = put_pair(e, st.hi, word);
                end
                else
                begin
                    // second escape is no low half: flush the high one, rescan
                    e = put_cp(e, st.hi);
                    if (jsu_pkg::is_high(word) && !fin)
                    begin
                        nst.mode = jsu_pkg::MODE_HIGH;
                        nst.hi   = word;
                    end
                    else
                    begin
                        e = put_cp(e, word);
                    end
                end
            end
            default:
            begin
                e = put(e, c);
            end
        endcase

        res.bytes = e.b;
        res.count = e.n;
        res.fin   = fin;
    end

endmodule

// ----- rtl/core/jsu_emit.sv -----
// Result register that drains the decoded bytes of one item, one per transfer.
module jsu_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jsu_pkg::dec_out_t d,
    input  logic              out_stall,
    output logic              free,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    jsu_pkg::obuf_t                bytes_reg, bytes_next;
    logic [jsu_pkg::OUT_CNT_W-1:0] count_reg, count_next;
    logic                          fin_reg, fin_next;
    logic                          xfer;

    assign out_valid = (count_reg != '0);
    assign out_byte  = bytes_reg[0];
    assign out_last  = fin_reg && (count_reg == 4'd1);
    assign xfer      = out_valid && !out_stall;
    assign free      = (count_reg == '0) || ((count_reg == 4'd1) && xfer);

    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        fin_next   = fin_reg;
        if (load)
        begin
            bytes_next = d.bytes;
            count_next = d.count;
            fin_next   = d.fin;
        end
        else if (xfer)
        begin
            // advance the queue by one byte
            bytes_next = {8'h00, bytes_reg[jsu_pkg::MAX_OUT-1:1]};
            count_next = count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        fin_reg   <= fin_next;
    end

endmodule

// ----- rtl/core/json_string_unescape_top.sv -----
// Top level of the JSON string unescaper: input register, scan state and output queue.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | in        | in_valid / in_stall   | in_byte[7:0], in_last
//  out     | out       | out_valid / out_stall | out_byte[7:0], out_last
//
//  One raw byte is taken per cycle while in_stall is low. An item decodes to
//  0 to 9 bytes, which the output queue sends at one byte per cycle while
//  out_stall is low; input stalls only while that queue holds more than the
//  byte now leaving. First output byte passes the input register and then the
//  output queue register before it is valid.
//  rst_n clears the scan mode and both valid flags at once.
//  A stalled output holds its byte; a stalled input holds the input register.
module json_string_unescape_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_valid,
    input  logic       out_stall
);

    // Input register
    logic                  in_vld_reg, in_vld_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;

    // Scan state: control part is reset, held digits and values are not
    jsu_pkg::mode_t        mode_reg;
    logic [1:0]            ndig_reg;
    logic [11:0]           acc_reg;
    jsu_pkg::byte_t [2:0]  dig_reg;
    logic [15:0]           hi_reg;

    jsu_pkg::scan_t        scan_cur;
    jsu_pkg::scan_t        scan_next;
    jsu_pkg::dec_out_t     dec;

    logic                  in_xfer;
    logic                  advance;
    logic                  emit_free;
    logic                  emit_load;

    assign scan_cur.mode = mode_reg;
    assign scan_cur.ndig = ndig_reg;
    assign scan_cur.acc  = acc_reg;
    assign scan_cur.dig  = dig_reg;
    assign scan_cur.hi   = hi_reg;

    jsu_decode u_decode (
        .st  (scan_cur),
        .c   (in_byte_reg),
        .fin (in_last_reg),
        .nst (scan_next),
        .res (dec)
    );

    // An item that yields no bytes may pass while the queue is still busy.
    assign advance   = in_vld_reg && (emit_free || (dec.count == '0));
    assign emit_load = advance && (dec.count != '0);
    assign in_stall  = in_vld_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_xfer)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= jsu_pkg::MODE_PLAIN;
            ndig_reg   <= 2'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (advance)
            begin
                mode_reg <= scan_next.mode;
                ndig_reg <= scan_next.ndig;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        if (advance)
        begin
            acc_reg <= scan_next.acc;
            dig_reg <= scan_next.dig;
            hi_reg  <= scan_next.hi;
        end
    end

    jsu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .d         (dec),
        .out_stall (out_stall),
        .free      (emit_free),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ----- rtl/core/jsu_check.sv -----
// Port-level checker for the JSON string unescaper, bound to the top level.
module jsu_check (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       out_valid,
    input logic       out_stall
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled output changed");

    // Never stall input while the output queue is empty.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output queue");

    // A result appears on an empty output only after an input transfer.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output appeared without an input transfer");

endmodule

bind json_string_unescape_top jsu_check u_check (.*);
